>>> sv/ihxc_pkg.sv
// Shared types, constants and helper functions of the hex record decoder.
package ihxc_pkg;

    localparam int BUFFER_DEPTH_DEF = 16;
    localparam int MAX_RESULTS      = 16;

    localparam logic [7:0] CH_ETX   = 8'h06;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_NL    = 8'h0A;

    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_EOF  = 2'd1;
    localparam logic [1:0] KIND_ETX  = 2'd2;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_high;
        logic       load_count;
        logic       load_type;
        logic       store_data;
        logic       emit_start;
        logic       crc_lo;
        logic       push_data;
        logic       push_end;
        logic [1:0] end_kind;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_etx;
        logic is_colon;
        logic is_nl;
        logic count_zero;
        logic pair_is_eof;
        logic idx_done;
        logic type_is_data;
        logic type_is_eof;
        logic emit_last;
        logic slot_free;
    } t_stat;

    // Lenient hex digit conversion; only the low four bits are kept.
    function automatic logic [3:0] nibble(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h61) begin
            v = c - 8'd87;
        end else if (c >= 8'h41) begin
            v = c - 8'd55;
        end else begin
            v = c - 8'd48;
        end
        return v[3:0];
    endfunction

    function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
        return {nibble(hi), nibble(lo)};
    endfunction

    // Four-bit slice of the reflected CRC32 table.
    function automatic logic [31:0] crc_tab(input logic [3:0] idx);
        logic [31:0] t;
        unique case (idx)
            4'h0: t = 32'h0000_0000;
            4'h1: t = 32'h1DB7_1064;
            4'h2: t = 32'h3B6E_20C8;
            4'h3: t = 32'h26D9_30AC;
            4'h4: t = 32'h76DC_4190;
            4'h5: t = 32'h6B6B_51F4;
            4'h6: t = 32'h4DB2_6158;
            4'h7: t = 32'h5005_713C;
            4'h8: t = 32'hEDB8_8320;
            4'h9: t = 32'hF00F_9344;
            4'hA: t = 32'hD6D6_A3E8;
            4'hB: t = 32'hCB61_B38C;
            4'hC: t = 32'h9B64_C2B0;
            4'hD: t = 32'h86D3_D2D4;
            4'hE: t = 32'hA00A_E278;
            4'hF: t = 32'hBDBD_F21C;
            default: t = 32'h0000_0000;
        endcase
        return t;
    endfunction

    // Folds one nibble into the running CRC.
    function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [3:0] nib);
        return {4'h0, crc[31:4]} ^ crc_tab(crc[3:0] ^ nib);
    endfunction

endpackage

>>> sv/ihxc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ihxc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/ihxc_ctrl.sv
// Controller: record parser state machine and byte emission sequencer.
module ihxc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_acc,
    input  ihxc_pkg::t_stat i_stat,
    output ihxc_pkg::t_cmd  o_cmd,
    output logic           o_idle
);

    localparam logic [2:0] PH_WAIT  = 3'd0;
    localparam logic [2:0] PH_COUNT = 3'd1;
    localparam logic [2:0] PH_ADDR  = 3'd2;
    localparam logic [2:0] PH_TYPE  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_SKIP  = 3'd5;

    localparam logic [1:0] E_IDLE = 2'd0;
    localparam logic [1:0] E_RD   = 2'd1;
    localparam logic [1:0] E_LO   = 2'd2;
    localparam logic [1:0] E_HI   = 2'd3;

    logic [2:0] r_phase, n_phase;
    logic [1:0] r_dpos, n_dpos;
    logic       r_fin, n_fin;
    logic [1:0] r_est, n_est;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_dpos  <= 2'd0;
            r_fin   <= 1'b0;
            r_est   <= E_IDLE;
        end else begin
            r_phase <= n_phase;
            r_dpos  <= n_dpos;
            r_fin   <= n_fin;
            r_est   <= n_est;
        end
    end

    assign o_idle = (r_est == E_IDLE);

    always_comb begin
        n_phase = r_phase;
        n_dpos  = r_dpos;
        n_fin   = r_fin;
        n_est   = r_est;
        o_cmd   = '0;

        if (i_in_acc && !r_fin) begin
            if (i_stat.is_etx) begin
                o_cmd.push_end = 1'b1;
                o_cmd.end_kind = ihxc_pkg::KIND_ETX;
                n_fin = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_COUNT: begin
                        if (r_dpos == 2'd0) begin
                            o_cmd.load_high = 1'b1;
                            n_dpos = 2'd1;
                        end else begin
                            o_cmd.load_count = 1'b1;
                            n_phase = PH_ADDR;
                            n_dpos = 2'd0;
                        end
                    end
                    PH_ADDR: begin
                        if (r_dpos == 2'd3) begin
                            n_phase = PH_TYPE;
                            n_dpos = 2'd0;
                        end else begin
                            n_dpos = r_dpos + 2'd1;
                        end
                    end
                    PH_TYPE: begin
                        if (r_dpos == 2'd0) begin
                            o_cmd.load_high = 1'b1;
                            n_dpos = 2'd1;
                        end else begin
                            o_cmd.load_type = 1'b1;
                            n_dpos = 2'd0;
                            if (!i_stat.count_zero) begin
                                n_phase = PH_DATA;
                            end else begin
                                n_phase = PH_SKIP;
                                if (i_stat.pair_is_eof) begin
                                    o_cmd.push_end = 1'b1;
                                    o_cmd.end_kind = ihxc_pkg::KIND_EOF;
                                    n_fin = 1'b1;
                                end
                            end
                        end
                    end
                    PH_DATA: begin
                        if (r_dpos == 2'd0) begin
                            o_cmd.load_high = 1'b1;
                            n_dpos = 2'd1;
                        end else begin
                            o_cmd.store_data = 1'b1;
                            n_dpos = 2'd0;
                            if (i_stat.idx_done) begin
                                n_phase = PH_SKIP;
                                if (i_stat.type_is_data) begin
                                    o_cmd.emit_start = 1'b1;
                                    n_est = E_RD;
                                end else if (i_stat.type_is_eof) begin
                                    o_cmd.push_end = 1'b1;
                                    o_cmd.end_kind = ihxc_pkg::KIND_EOF;
                                    n_fin = 1'b1;
                                end
                            end
                        end
                    end
                    PH_SKIP: begin
                        if (i_stat.is_nl) begin
                            n_phase = PH_WAIT;
                        end
                    end
                    default: begin
                        if (i_stat.is_colon) begin
                            n_phase = PH_COUNT;
                            n_dpos = 2'd0;
                        end else begin
                            n_phase = PH_WAIT;
                        end
                    end
                endcase
            end
        end

        unique case (r_est)
            E_RD: n_est = E_LO;
            E_LO: begin
                o_cmd.crc_lo = 1'b1;
                n_est = E_HI;
            end
            E_HI: begin
                if (i_stat.slot_free) begin
                    o_cmd.push_data = 1'b1;
                    n_est = i_stat.emit_last ? E_IDLE : E_RD;
                end
            end
            default: ;
        endcase
    end

endmodule

>>> sv/ihxc_dp.sv
// Datapath: record fields, data buffer, CRC and byte count, output register.
module ihxc_dp #(
    parameter int BUFFER_DEPTH = ihxc_pkg::BUFFER_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_rx_char,
    input  logic            i_cfg_we,
    input  logic [31:0]     i_cfg_data,
    input  logic            i_out_take,
    input  ihxc_pkg::t_cmd  i_cmd,
    output ihxc_pkg::t_stat o_stat,
    output logic            o_valid,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_data_byte,
    output logic            o_last,
    output logic [31:0]     o_crc_value,
    output logic            o_crc_ok,
    output logic [31:0]     o_byte_total
);

    localparam int AW  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CAP = (BUFFER_DEPTH < ihxc_pkg::MAX_RESULTS) ?
                         BUFFER_DEPTH : ihxc_pkg::MAX_RESULTS;

    logic [31:0]   r_expected;
    logic [7:0]    r_count;
    logic [7:0]    r_type;
    logic [7:0]    r_index;
    logic [7:0]    r_high;
    logic [31:0]   r_crc;
    logic [31:0]   r_total;
    logic [AW-1:0] r_eidx;
    logic [7:0]    r_byte;

    logic          r_out_valid;
    logic [1:0]    r_kind;
    logic [7:0]    r_data;
    logic          r_last;
    logic [31:0]   r_crc_out;
    logic          r_ok;
    logic [31:0]   r_total_out;

    logic [7:0]    w_pair;
    logic [7:0]    w_n;
    logic [7:0]    w_rdata;
    logic [31:0]   w_crc_hi;
    logic          w_we;

    assign w_pair   = ihxc_pkg::hex_pair(r_high, i_rx_char);
    assign w_n      = (r_count > 8'(CAP)) ? 8'(CAP) : r_count;
    assign w_crc_hi = ihxc_pkg::crc_step(r_crc, r_byte[7:4]);
    assign w_we     = i_cmd.store_data && (r_index < 8'(BUFFER_DEPTH));

    ihxc_ram #(
        .WIDTH(8),
        .DEPTH(BUFFER_DEPTH)
    ) u_buf (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_index[AW-1:0]),
        .i_wdata(w_pair),
        .i_raddr(r_eidx),
        .o_rdata(w_rdata)
    );

    always_comb begin
        o_stat.is_etx       = (i_rx_char == ihxc_pkg::CH_ETX);
        o_stat.is_colon     = (i_rx_char == ihxc_pkg::CH_COLON);
        o_stat.is_nl        = (i_rx_char == ihxc_pkg::CH_NL);
        o_stat.count_zero   = (r_count == 8'd0);
        o_stat.pair_is_eof  = (w_pair == ihxc_pkg::REC_EOF);
        o_stat.idx_done     = ((r_index + 8'd1) >= r_count);
        o_stat.type_is_data = (r_type == ihxc_pkg::REC_DATA);
        o_stat.type_is_eof  = (r_type == ihxc_pkg::REC_EOF);
        o_stat.emit_last    = ((8'(r_eidx) + 8'd1) == w_n);
        o_stat.slot_free    = !r_out_valid || i_out_take;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected  <= 32'd0;
            r_count     <= 8'd0;
            r_type      <= 8'd0;
            r_index     <= 8'd0;
            r_high      <= 8'd0;
            r_crc       <= ihxc_pkg::CRC_INIT;
            r_total     <= 32'd0;
            r_eidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_expected <= i_cfg_data;
            end
            if (i_cmd.load_high) begin
                r_high <= i_rx_char;
            end
            if (i_cmd.load_count) begin
                r_count <= w_pair;
            end
            if (i_cmd.load_type) begin
                r_type  <= w_pair;
                r_index <= 8'd0;
            end
            if (i_cmd.store_data) begin
                r_index <= r_index + 8'd1;
            end
            if (i_cmd.emit_start) begin
                r_eidx <= '0;
            end
            if (i_cmd.crc_lo) begin
                r_crc <= ihxc_pkg::crc_step(r_crc, w_rdata[3:0]);
            end
            if (i_cmd.push_data) begin
                r_crc   <= w_crc_hi;
                r_total <= r_total + 32'd1;
                r_eidx  <= r_eidx + AW'(1);
            end
            if (i_cmd.push_data || i_cmd.push_end) begin
                r_out_valid <= 1'b1;
            end else if (i_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.crc_lo) begin
            r_byte <= w_rdata;
        end
        if (i_cmd.push_data) begin
            r_kind      <= ihxc_pkg::KIND_DATA;
            r_data      <= r_byte;
            r_last      <= o_stat.emit_last;
            r_crc_out   <= ~w_crc_hi;
            r_ok        <= 1'b0;
            r_total_out <= r_total + 32'd1;
        end else if (i_cmd.push_end) begin
            r_kind      <= i_cmd.end_kind;
            r_data      <= 8'd0;
            r_last      <= 1'b1;
            r_crc_out   <= ~r_crc;
            r_ok        <= (~r_crc == r_expected);
            r_total_out <= r_total;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_kind       = r_kind;
    assign o_data_byte  = r_data;
    assign o_last       = r_last;
    assign o_crc_value  = r_crc_out;
    assign o_crc_ok     = r_ok;
    assign o_byte_total = r_total_out;

endmodule

>>> sv/intel_hex_record_decoder_crc32_top.sv
// Top level of the Intel HEX record decoder with running CRC32.
//
// The block takes one received character per input beat and parses Intel HEX
// records: a colon, a two-digit byte count, four ignored address characters,
// a two-digit record type and then the data digits, two per byte. Hex digits
// are converted leniently and never rejected. Characters are buffered until a
// data record completes; then its bytes (at most the buffer depth and never
// more than sixteen) leave as result beats of kind zero, each folded into a
// reflected CRC32 and counted in the byte total, with last set on the final
// byte of the record. An end-of-file record or an ETX character ends the
// transfer with a single result beat carrying the final CRC, the match flag
// against the expected CRC register and the byte total; after that every
// character is taken and dropped until reset. A character that causes no
// result is simply absorbed; a new character is taken whenever the emitter
// is idle and the output register is empty or being emptied. Each byte
// takes a registered buffer read, then enters the CRC four bits a cycle via
// a small constant table, the high nibble once the output has room. The
// expected CRC is written through its own port, which is always ready, and
// should only be changed while the decoder is idle.
module intel_hex_record_decoder_crc32_top #(
    parameter int BUFFER_DEPTH = ihxc_pkg::BUFFER_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Character input channel.
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_char,
    // Expected CRC write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    // Result channel.
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic        o_last,
    output logic [31:0] o_crc_value,
    output logic        o_crc_ok,
    output logic [31:0] o_byte_total
);

    ihxc_pkg::t_cmd  w_cmd;
    ihxc_pkg::t_stat w_stat;
    logic            w_idle;
    logic            w_in_acc;

    // Characters are taken only while no record is being emitted and the
    // output register has room for a possible end result.
    assign o_ready     = w_idle && w_stat.slot_free;
    assign w_in_acc    = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    ihxc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in_acc(w_in_acc),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_idle  (w_idle)
    );

    ihxc_dp #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_char   (i_rx_char),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_out_take  (o_valid && i_ready),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte),
        .o_last      (o_last),
        .o_crc_value (o_crc_value),
        .o_crc_ok    (o_crc_ok),
        .o_byte_total(o_byte_total)
    );

    // A result is only written into the output register when it has room.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.push_data || w_cmd.push_end) |-> w_stat.slot_free)
        else $error("result pushed into a full output register");

    // Data bytes and the end result never compete for the output register.
    a_push_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.push_data && w_cmd.push_end))
        else $error("data byte and end result pushed together");

    // Once the end result is taken, nothing else ever comes out.
    a_quiet_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && (o_kind != ihxc_pkg::KIND_DATA)) |=> !o_valid)
        else $error("result produced after the end of the transfer");

    // A pushed data byte shows up as a data result in the next cycle.
    a_data_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push_data |=> (o_valid && (o_kind == ihxc_pkg::KIND_DATA) && !o_crc_ok))
        else $error("data byte result malformed");

endmodule
